/* hdl/hsv2rgb_pkg.sv */
// ----------------------------------------------------------------------------
// HSV to RGB converter package
// Shared widths, fixed-point constants and helper functions.
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

  localparam int FRAC_BITS = 16;
  localparam int IN_W      = 18;
  localparam int BYTE_W    = 8;
  localparam int UNIT_W    = FRAC_BITS + 1;
  localparam int CMP_W     = (FRAC_BITS + 2 > IN_W) ? FRAC_BITS + 2 : IN_W;
  localparam int H6_W      = FRAC_BITS + 3;
  localparam int SEXT_W    = 3;
  localparam int PROD_W    = 2 * FRAC_BITS + 1;

  localparam logic [UNIT_W-1:0]       ONE     = UNIT_W'(1) << FRAC_BITS;
  localparam logic signed [CMP_W-1:0] ONE_CMP = CMP_W'(1) << FRAC_BITS;
  localparam logic [PROD_W-1:0]       PROD_MAX = PROD_W'(1) << (2 * FRAC_BITS);

  typedef enum logic [SEXT_W-1:0] {
    SEXT_RED_YEL = 3'd0,
    SEXT_YEL_GRN = 3'd1,
    SEXT_GRN_CYN = 3'd2,
    SEXT_CYN_BLU = 3'd3,
    SEXT_BLU_MAG = 3'd4,
    SEXT_MAG_RED = 3'd5
  } sextant_t;

  function automatic logic [UNIT_W-1:0] clamp_unit(input logic signed [IN_W-1:0] raw);
    logic signed [CMP_W-1:0] wide;
    logic [UNIT_W-1:0]       res;
    wide = CMP_W'(raw);
    if (wide < 0) begin
      res = '0;
    end else if (wide > ONE_CMP) begin
      res = ONE;
    end else begin
      res = wide[UNIT_W-1:0];
    end
    return res;
  endfunction

  function automatic logic [BYTE_W-1:0] prod_to_byte(input logic [PROD_W-1:0] prod);
    logic [PROD_W+BYTE_W-1:0] scaled;
    scaled = {prod, {BYTE_W{1'b0}}} - {{BYTE_W{1'b0}}, prod};
    return scaled[2*FRAC_BITS+BYTE_W-1:2*FRAC_BITS];
  endfunction

endpackage

/* hdl/hsv2rgb_if.sv */
// ----------------------------------------------------------------------------
// HSV to RGB stream interfaces
// Valid/ready channels for the HSV input pixels and the RGB result pixels.
// ----------------------------------------------------------------------------
interface hsv2rgb_in_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [hsv2rgb_pkg::IN_W-1:0]    hue_in;
  logic signed [hsv2rgb_pkg::IN_W-1:0]    sat_in;
  logic signed [hsv2rgb_pkg::IN_W-1:0]    val_in;
  logic        [hsv2rgb_pkg::BYTE_W-1:0]  alpha_in;

  modport source (output valid, hue_in, sat_in, val_in, alpha_in, input ready);
  modport sink   (input valid, hue_in, sat_in, val_in, alpha_in, output ready);
endinterface

interface hsv2rgb_out_if;
  logic                              valid;
  logic                              ready;
  logic [hsv2rgb_pkg::BYTE_W-1:0]    red_out;
  logic [hsv2rgb_pkg::BYTE_W-1:0]    green_out;
  logic [hsv2rgb_pkg::BYTE_W-1:0]    blue_out;
  logic [hsv2rgb_pkg::BYTE_W-1:0]    alpha_out;

  modport source (output valid, red_out, green_out, blue_out, alpha_out, input ready);
  modport sink   (input valid, red_out, green_out, blue_out, alpha_out, output ready);
endinterface

/* hdl/hsv_to_rgb_converter.sv */
// Accepted transactions move through stage registers 1 to 4 in order; throughput is
// one transaction per cycle while the output is ready. The four pipeline registers
// hold a stage whose successor is stalled, and input ready follows stage 1's hold.
// Reset clears all stage valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
// HSV to RGB converter
// Four-stage pipeline: clamp and hue scaling, saturation products, value
// products, byte conversion with channel selection.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter (
  input logic          clk,
  input logic          rst,
  hsv2rgb_in_if.sink   hsv,
  hsv2rgb_out_if.source rgb
);

  localparam int FB = hsv2rgb_pkg::FRAC_BITS;
  localparam int UW = hsv2rgb_pkg::UNIT_W;
  localparam int BW = hsv2rgb_pkg::BYTE_W;
  localparam int PW = hsv2rgb_pkg::PROD_W;

  logic en1, en2, en3, en4;
  logic v1, v2, v3, v4;

  // Stage 1 registers.
  logic [hsv2rgb_pkg::SEXT_W-1:0] sext1;
  logic [FB-1:0]                  frac1;
  logic [UW-1:0]                  sat1, val1;
  logic [BW-1:0]                  alpha1;

  // Stage 2 registers.
  logic [hsv2rgb_pkg::SEXT_W-1:0] sext2;
  logic [UW-1:0]                  xp2, xq2, xt2, val2;
  logic [BW-1:0]                  alpha2;

  // Stage 3 registers.
  logic [hsv2rgb_pkg::SEXT_W-1:0] sext3;
  logic [PW-1:0]                  prod_p3, prod_q3, prod_t3;
  logic [BW-1:0]                  vb3, alpha3;

  // Stage 4 registers.
  logic [BW-1:0] red4, green4, blue4, alpha4;

  assign en4 = !v4 || rgb.ready;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign hsv.ready = en1;

  // Stage 0 logic: clamp and scale the hue by six.
  logic [UW-1:0]                  hue_c;
  logic [hsv2rgb_pkg::H6_W-1:0]   h6;

  always_comb begin
    hue_c = hsv2rgb_pkg::clamp_unit(hsv.hue_in);
    if (hue_c == hsv2rgb_pkg::ONE) begin
      h6 = '0;
    end else begin
      h6 = (hsv2rgb_pkg::H6_W'(hue_c) << 2) + (hsv2rgb_pkg::H6_W'(hue_c) << 1);
    end
  end

  // Stage 1 logic: saturation times fraction and its complement.
  logic [FB:0]     omf1;
  logic [2*FB:0]   sf_full, snf_full;
  logic [UW-1:0]   sf1, snf1;

  always_comb begin
    omf1     = hsv2rgb_pkg::ONE - {1'b0, frac1};
    sf_full  = (2*FB+1)'(sat1) * (2*FB+1)'(frac1);
    snf_full = (2*FB+1)'(sat1) * (2*FB+1)'(omf1);
    sf1      = sf_full[2*FB:FB];
    snf1     = snf_full[2*FB:FB];
  end

  // Stage 2 logic: value products and the value byte.
  logic [2*UW-1:0]  pp_full, pq_full, pt_full;
  logic [UW+BW-1:0] v255;

  always_comb begin
    pp_full = (2*UW)'(val2) * (2*UW)'(xp2);
    pq_full = (2*UW)'(val2) * (2*UW)'(xq2);
    pt_full = (2*UW)'(val2) * (2*UW)'(xt2);
    v255    = {val2, {BW{1'b0}}} - {{BW{1'b0}}, val2};
  end

  // Stage 3 logic: bytes and channel order.
  logic [BW-1:0] pb3, qb3, tb3;
  logic [BW-1:0] red_c, green_c, blue_c;

  always_comb begin
    pb3 = hsv2rgb_pkg::prod_to_byte(prod_p3);
    qb3 = hsv2rgb_pkg::prod_to_byte(prod_q3);
    tb3 = hsv2rgb_pkg::prod_to_byte(prod_t3);
    case (hsv2rgb_pkg::sextant_t'(sext3))
      hsv2rgb_pkg::SEXT_RED_YEL: begin
        red_c = vb3; green_c = tb3; blue_c = pb3;
      end
      hsv2rgb_pkg::SEXT_YEL_GRN: begin
        red_c = qb3; green_c = vb3; blue_c = pb3;
      end
      hsv2rgb_pkg::SEXT_GRN_CYN: begin
        red_c = pb3; green_c = vb3; blue_c = tb3;
      end
      hsv2rgb_pkg::SEXT_CYN_BLU: begin
        red_c = pb3; green_c = qb3; blue_c = vb3;
      end
      hsv2rgb_pkg::SEXT_BLU_MAG: begin
        red_c = tb3; green_c = pb3; blue_c = vb3;
      end
      default: begin
        red_c = vb3; green_c = pb3; blue_c = qb3;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (en1) v1 <= hsv.valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
    end
    if (en1) begin
      sext1  <= h6[hsv2rgb_pkg::H6_W-1:FB];
      frac1  <= h6[FB-1:0];
      sat1   <= hsv2rgb_pkg::clamp_unit(hsv.sat_in);
      val1   <= hsv2rgb_pkg::clamp_unit(hsv.val_in);
      alpha1 <= hsv.alpha_in;
    end
    if (en2) begin
      sext2  <= sext1;
      xp2    <= hsv2rgb_pkg::ONE - sat1;
      xq2    <= hsv2rgb_pkg::ONE - sf1;
      xt2    <= hsv2rgb_pkg::ONE - snf1;
      val2   <= val1;
      alpha2 <= alpha1;
    end
    if (en3) begin
      sext3   <= sext2;
      prod_p3 <= pp_full[PW-1:0];
      prod_q3 <= pq_full[PW-1:0];
      prod_t3 <= pt_full[PW-1:0];
      vb3     <= v255[FB+BW-1:FB];
      alpha3  <= alpha2;
    end
    if (en4) begin
      red4   <= red_c;
      green4 <= green_c;
      blue4  <= blue_c;
      alpha4 <= alpha3;
    end
  end

  assign rgb.valid     = v4;
  assign rgb.red_out   = red4;
  assign rgb.green_out = green4;
  assign rgb.blue_out  = blue4;
  assign rgb.alpha_out = alpha4;

  a_in_enters_stage1: assert property (@(posedge clk) disable iff (rst)
    hsv.valid && hsv.ready |=> v1)
    else $error("Accepted transaction did not reach stage 1.");

  a_stage1_holds: assert property (@(posedge clk) disable iff (rst)
    v1 && !en2 |=> v1 && $stable(sext1) && $stable(frac1) && $stable(val1))
    else $error("Stalled stage 1 lost or changed its transaction.");

  a_sextant_range: assert property (@(posedge clk) disable iff (rst)
    v1 |-> sext1 <= hsv2rgb_pkg::SEXT_W'(hsv2rgb_pkg::SEXT_MAG_RED))
    else $error("Hue sextant out of range.");

  a_prod_range: assert property (@(posedge clk) disable iff (rst)
    v3 |-> prod_p3 <= hsv2rgb_pkg::PROD_MAX && prod_q3 <= hsv2rgb_pkg::PROD_MAX
        && prod_t3 <= hsv2rgb_pkg::PROD_MAX)
    else $error("Channel product exceeds one.");

  a_output_holds: assert property (@(posedge clk) disable iff (rst)
    v3 && !en3 |=> v3 && v4)
    else $error("Stall chain dropped a transaction.");

endmodule
